FILE: rtl/edsf_pkg.sv
// Package for the echo distance smoothing filter: widths, defaults, register indexes and states.
package edsf_pkg;

  // Distance values are Q11.8 centimetres.
  localparam int DIST_W = 19;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register widths.
  localparam int SCALE_W = 16;
  localparam int WEIGHT_W = 9;
  localparam int CAPTURE_W = 16;

  // Q1.8 unity weight.
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

  // Reset values of the configuration registers.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1114;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd77;
  localparam logic [DIST_W-1:0] MAX_STEP_RESET = 19'd12800;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 19;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISTANCE_SCALE = 2'd0,
    REG_NEW_SAMPLE_WEIGHT = 2'd1,
    REG_MAX_STEP = 2'd2
  } cfg_reg_t;

  // Default structural parameters.
  localparam int CHANNELS_DEFAULT = 2;
  localparam int TIMER_BITS_DEFAULT = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ROUND,
    ST_BLEND,
    ST_UPDATE
  } state_t;

endpackage

FILE: rtl/echo_distance_smoothing_filter.sv
// Echo distance smoothing filter: pulse width to distance, per-channel smoother, spike limiter.
//
//   Port group        Direction  Handshake               Contents
//   echo              in         echo_valid/echo_stall   channel, rise_time, fall_time
//   result            out        result_valid/result_stall channel_out, distance, spike_rejected
//   cfg               in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each echo transaction passes these steps from acceptance until its result is loaded
// into the output register: the capture difference and the state memory read, then
// the scale multiply, the rounding to Q11.8, the two smoother products and
// the final sum with the spike compare and memory write-back. The steps form a chain
// of dependent multiplies through the single-port state memory. A new echo is taken
// while a finished result still waits in the output register; only the final step waits
// when that register is full and stalled. Reset is synchronous and active high: it clears
// the control state, restores the register defaults and clears the per-channel primed
// flags, so no memory clearing pass is needed. An echo on a channel at or above
// CHANNELS is accepted and dropped without a result.
module echo_distance_smoothing_filter #(
  parameter int CHANNELS = edsf_pkg::CHANNELS_DEFAULT,
  parameter int TIMER_BITS = edsf_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             echo_valid,
  output logic                             echo_stall,
  input  logic                             channel,
  input  logic [edsf_pkg::CAPTURE_W-1:0]   rise_time,
  input  logic [edsf_pkg::CAPTURE_W-1:0]   fall_time,

  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             channel_out,
  output logic [edsf_pkg::DIST_W-1:0]      distance,
  output logic                             spike_rejected,

  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [edsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edsf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DIST_W = edsf_pkg::DIST_W;
  localparam int WEIGHT_W = edsf_pkg::WEIGHT_W;
  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Pulse width times scale, then rounded half up to Q.8.
  localparam int PROD_W = TIMER_BITS + edsf_pkg::SCALE_W;
  localparam int Q8_W = PROD_W - 7;
  // Smoother products: 19-bit distance times 9-bit weight.
  localparam int BLEND_W = DIST_W + WEIGHT_W;
  localparam int MEM_W = 2 * DIST_W;

  // Configuration registers.
  logic [edsf_pkg::SCALE_W-1:0] distance_scale;
  logic [WEIGHT_W-1:0]          new_sample_weight;
  logic [DIST_W-1:0]            max_step;

  // Control.
  edsf_pkg::state_t state, state_next;
  logic echo_take;
  logic item_in_range;
  logic result_load;

  // Item registers.
  logic                  item_channel;
  logic [ADDR_W-1:0]     item_addr;
  logic [TIMER_BITS-1:0] pulse_width;
  logic [PROD_W-1:0]     scaled;
  logic [DIST_W-1:0]     raw_dist;
  logic [BLEND_W-1:0]    prod_prev;
  logic [BLEND_W-1:0]    prod_new;

  // State memory holds {smoothed, held} per channel; primed flags live in flip-flops.
  logic [MEM_W-1:0]    state_mem [CHANNELS];
  logic [MEM_W-1:0]    mem_rd_data;
  logic [MEM_W-1:0]    mem_wr_data;
  logic [CHANNELS-1:0] primed;

  // Datapath combinational signals.
  logic [PROD_W:0]      round_sum;
  logic [Q8_W-1:0]      q8;
  logic [DIST_W-1:0]    raw_next;
  logic [WEIGHT_W-1:0]  weight_eff;
  logic [WEIGHT_W-1:0]  weight_keep;
  logic [DIST_W-1:0]    prev_smoothed;
  logic [DIST_W-1:0]    prev_held;
  logic [BLEND_W-1:0]   blend_sum;
  logic [DIST_W-1:0]    smoothed_next;
  logic [DIST_W-1:0]    step_size;
  logic                 step_ok;
  logic                 item_primed;
  logic [DIST_W-1:0]    held_next;
  logic [DIST_W-1:0]    dist_next;
  logic                 rejected_next;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes are always taken; an index past the register
  // list is accepted and has no effect.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_scale <= edsf_pkg::SCALE_RESET;
      new_sample_weight <= edsf_pkg::WEIGHT_RESET;
      max_step <= edsf_pkg::MAX_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        edsf_pkg::REG_DISTANCE_SCALE: begin
          distance_scale <= cfg_data[edsf_pkg::SCALE_W-1:0];
        end
        edsf_pkg::REG_NEW_SAMPLE_WEIGHT: begin
          new_sample_weight <= cfg_data[WEIGHT_W-1:0];
        end
        edsf_pkg::REG_MAX_STEP: begin
          max_step <= cfg_data[DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. One item is in flight at a time, so the memory write of an
  // item always lands before the read of the next one and no forwarding is
  // needed.
  // ---------------------------------------------------------------------------
  assign echo_take = echo_valid && !echo_stall;
  assign item_in_range = (32'(channel) < CHANNELS);

  always_comb begin
    state_next = state;
    unique case (state)
      edsf_pkg::ST_IDLE: begin
        if (echo_take && item_in_range) begin
          state_next = edsf_pkg::ST_SCALE;
        end
      end
      edsf_pkg::ST_SCALE: begin
        state_next = edsf_pkg::ST_ROUND;
      end
      edsf_pkg::ST_ROUND: begin
        state_next = edsf_pkg::ST_BLEND;
      end
      edsf_pkg::ST_BLEND: begin
        state_next = edsf_pkg::ST_UPDATE;
      end
      edsf_pkg::ST_UPDATE: begin
        if (!result_valid || !result_stall) begin
          state_next = edsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = edsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    echo_stall = 1'b1;
    result_load = 1'b0;
    unique case (state)
      edsf_pkg::ST_IDLE: begin
        echo_stall = 1'b0;
      end
      edsf_pkg::ST_UPDATE: begin
        result_load = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------

  // Rounding from Q.16 to Q.8, half up, with saturation at the top of Q11.8.
  assign round_sum = (PROD_W + 1)'(scaled) + (PROD_W + 1)'(128);
  assign q8 = round_sum[PROD_W:8];
  always_comb begin
    if ((q8 >> DIST_W) != '0) begin
      raw_next = edsf_pkg::DIST_MAX;
    end else begin
      raw_next = DIST_W'(q8);
    end
  end

  // A weight above one counts as one.
  assign weight_eff = new_sample_weight[WEIGHT_W-1] ? edsf_pkg::WEIGHT_ONE : new_sample_weight;
  assign weight_keep = edsf_pkg::WEIGHT_ONE - weight_eff;

  assign prev_smoothed = mem_rd_data[MEM_W-1:DIST_W];
  assign prev_held = mem_rd_data[DIST_W-1:0];

  // The blended sum stays below 2^27, so the Q11.8 result never overflows.
  assign blend_sum = prod_prev + prod_new + BLEND_W'(128);
  assign smoothed_next = blend_sum[8 +: DIST_W];

  assign step_size = (smoothed_next >= prev_held) ? (smoothed_next - prev_held)
                                                  : (prev_held - smoothed_next);
  assign step_ok = (step_size <= max_step);
  assign item_primed = primed[item_addr];

  always_comb begin
    if (!item_primed) begin
      // The first sample of a channel seeds both the smoother and the held value.
      mem_wr_data = {raw_dist, raw_dist};
      held_next = raw_dist;
      dist_next = raw_dist;
      rejected_next = 1'b0;
    end else begin
      held_next = step_ok ? smoothed_next : prev_held;
      mem_wr_data = {smoothed_next, held_next};
      dist_next = held_next;
      rejected_next = !step_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (echo_take) begin
      item_channel <= channel;
      item_addr <= ADDR_W'(channel);
      pulse_width <= TIMER_BITS'(fall_time) - TIMER_BITS'(rise_time);
    end
    if (state == edsf_pkg::ST_SCALE) begin
      scaled <= PROD_W'(pulse_width) * PROD_W'(distance_scale);
    end
    if (state == edsf_pkg::ST_ROUND) begin
      raw_dist <= raw_next;
    end
    if (state == edsf_pkg::ST_BLEND) begin
      prod_prev <= BLEND_W'(prev_smoothed) * BLEND_W'(weight_keep);
      prod_new <= BLEND_W'(raw_dist) * BLEND_W'(weight_eff);
    end
  end

  // State memory: read when an echo is accepted, written back in the final step.
  always_ff @(posedge clk) begin
    if (echo_take) begin
      mem_rd_data <= state_mem[ADDR_W'(channel)];
    end
    if (result_load) begin
      state_mem[item_addr] <= mem_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= '0;
    end else if (result_load) begin
      primed[item_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      channel_out <= item_channel;
      distance <= dist_next;
      spike_rejected <= rejected_next;
    end
  end

endmodule

FILE: tb/sv/tb_echo_distance_smoothing_filter.sv
// Self-checking testbench for the echo distance smoothing filter.
module tb_echo_distance_smoothing_filter;

  // Local copies of the package constants used throughout the bench.
  localparam int DIST_W = edsf_pkg::DIST_W;
  localparam int SCALE_W = edsf_pkg::SCALE_W;
  localparam int WEIGHT_W = edsf_pkg::WEIGHT_W;
  localparam int CAPTURE_W = edsf_pkg::CAPTURE_W;
  localparam int CFG_INDEX_W = edsf_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W = edsf_pkg::CFG_DATA_W;
  localparam logic [DIST_W-1:0] DIST_MAX = edsf_pkg::DIST_MAX;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = edsf_pkg::WEIGHT_ONE;
  localparam logic [SCALE_W-1:0] SCALE_RESET = edsf_pkg::SCALE_RESET;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = edsf_pkg::WEIGHT_RESET;
  localparam logic [DIST_W-1:0] MAX_STEP_RESET = edsf_pkg::MAX_STEP_RESET;

  typedef edsf_pkg::cfg_reg_t cfg_reg_t;
  localparam cfg_reg_t REG_DISTANCE_SCALE = edsf_pkg::REG_DISTANCE_SCALE;
  localparam cfg_reg_t REG_NEW_SAMPLE_WEIGHT = edsf_pkg::REG_NEW_SAMPLE_WEIGHT;
  localparam cfg_reg_t REG_MAX_STEP = edsf_pkg::REG_MAX_STEP;

  // The watchdog ends the run after this many cycles without any accepted transaction.
  // The slowest legal stretch is a sender gap, the filter's processing steps, a receiver
  // stall and a settling pause before a register write.
  localparam int WATCHDOG_LIMIT = 2000;
  // Pause after the last expected result before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 10;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 75;

  typedef enum logic {
    ROW_ECHO,
    ROW_CFG
  } row_kind_t;

  // One row of the directed table. Echo rows with typed set carry the expected report
  // written out by hand; all other echo rows are checked against the predictor.
  typedef struct packed {
    row_kind_t               kind;
    logic                    ch;
    logic [CAPTURE_W-1:0]    rise;
    logic [CAPTURE_W-1:0]    fall;
    logic                    typed;
    logic [DIST_W-1:0]       exp_dist;
    logic                    exp_rej;
    cfg_reg_t                reg_sel;
    logic [CFG_DATA_W-1:0]   reg_value;
  } stim_row_t;

  // One distance report as the block emits it.
  typedef struct packed {
    logic              ch;
    logic [DIST_W-1:0] dist_q8;
    logic              rejected;
  } distance_report_t;

  logic                   clk;
  logic                   rst;
  logic                   echo_valid;
  logic                   echo_stall;
  logic                   channel;
  logic [CAPTURE_W-1:0]   rise_time;
  logic [CAPTURE_W-1:0]   fall_time;
  logic                   result_valid;
  logic                   result_stall;
  logic                   channel_out;
  logic [DIST_W-1:0]      distance;
  logic                   spike_rejected;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  echo_distance_smoothing_filter dut (
    .clk            (clk),
    .rst            (rst),
    .echo_valid     (echo_valid),
    .echo_stall     (echo_stall),
    .channel        (channel),
    .rise_time      (rise_time),
    .fall_time      (fall_time),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .channel_out    (channel_out),
    .distance       (distance),
    .spike_rejected (spike_rejected),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Predictor copy of the configuration registers, starting from their reset values.
  logic [SCALE_W-1:0]  cur_scale = SCALE_RESET;
  logic [WEIGHT_W-1:0] cur_weight = WEIGHT_RESET;
  logic [DIST_W-1:0]   cur_max_step = MAX_STEP_RESET;

  // Predictor copy of the per-channel filter state; everything is clear after reset.
  logic [DIST_W-1:0] ch_smoothed [2] = '{default: '0};
  logic [DIST_W-1:0] ch_held [2] = '{default: '0};
  logic              ch_primed [2] = '{default: 1'b0};

  // Reports still owed by the block, oldest first.
  distance_report_t pending_reports [$];

  int error_count = 0;
  int idle_cycles = 0;

  // Idling control: while idling is set, the sender inserts gaps and the receiver
  // stalls in bursts, each gap or burst starting with the given odds.
  bit idling = 1'b1;
  int gap_pct = 20;
  int stall_pct = 20;
  int stall_left = 0;

  // The directed table. It walks through first samples on both channels, a spike
  // against a zero held value, capture wrap at both ends, saturation at the largest
  // scale, a weight above one, a zero step limit that rejects everything that moves,
  // a zero weight that freezes the smoother, and a return to the default settings.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ECHO, 1'b0, 16'h0000, 16'h0000, 1'b1, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b1, 16'h1234, 16'h1234, 1'b1, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b0, 16'h0000, 16'h0000, 1'b1, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 19'd0, 1'b1, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b1, 16'h8000, 16'h7FFF, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b0, 16'h0100, 16'h0F00, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE,
      19'd65535},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_NEW_SAMPLE_WEIGHT,
      19'd256},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_MAX_STEP, 19'd524287},
    '{ROW_ECHO, 1'b0, 16'h0000, 16'hFFFF, 1'b1, 19'd524287, 1'b0, REG_DISTANCE_SCALE,
      19'd0},
    '{ROW_ECHO, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 19'd524287, 1'b0, REG_DISTANCE_SCALE,
      19'd0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_NEW_SAMPLE_WEIGHT,
      19'd511},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_MAX_STEP, 19'd0},
    '{ROW_ECHO, 1'b0, 16'hAAAA, 16'hAAAA, 1'b1, 19'd524287, 1'b1, REG_DISTANCE_SCALE,
      19'd0},
    '{ROW_ECHO, 1'b0, 16'h5555, 16'h5555, 1'b1, 19'd524287, 1'b1, REG_DISTANCE_SCALE,
      19'd0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_NEW_SAMPLE_WEIGHT, 19'd0},
    '{ROW_ECHO, 1'b1, 16'h0000, 16'hFFFF, 1'b1, 19'd524287, 1'b0, REG_DISTANCE_SCALE,
      19'd0},
    '{ROW_ECHO, 1'b0, 16'h1234, 16'hFEDC, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd1114},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_NEW_SAMPLE_WEIGHT,
      19'd77},
    '{ROW_CFG, 1'b0, 16'h0000, 16'h0000, 1'b0, 19'd0, 1'b0, REG_MAX_STEP, 19'd12800},
    '{ROW_ECHO, 1'b1, 16'h0000, 16'h2000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0},
    '{ROW_ECHO, 1'b0, 16'h0000, 16'h2000, 1'b0, 19'd0, 1'b0, REG_DISTANCE_SCALE, 19'd0}
  };

  // Free-running clock with a period of 8 time units.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Prints one line per failure and keeps count; the run always goes on to its end.
  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Works out the report for one echo and advances the predictor state. The pulse
  // width wraps at the capture width, is scaled and rounded half up to Q11.8 and then
  // saturated. A primed channel blends it into the smoothed value, and the blend is
  // reported only if it stays within the step limit of the last accepted distance.
  function automatic distance_report_t filter_echo(input logic ch,
                                                   input logic [CAPTURE_W-1:0] rise,
                                                   input logic [CAPTURE_W-1:0] fall);
    logic [CAPTURE_W-1:0] pulse;
    logic [63:0]          acc;
    logic [DIST_W-1:0]    raw;
    logic [DIST_W-1:0]    blend;
    logic [DIST_W-1:0]    diff;
    logic [WEIGHT_W-1:0]  w;
    distance_report_t     rpt;

    pulse = fall - rise;
    acc = (64'(pulse) * 64'(cur_scale) + 64'd128) >> 8;
    raw = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
    rpt.ch = ch;
    rpt.rejected = 1'b0;
    if (!ch_primed[ch]) begin
      ch_smoothed[ch] = raw;
      ch_held[ch] = raw;
      ch_primed[ch] = 1'b1;
      rpt.dist_q8 = raw;
    end else begin
      // A weight above one behaves as exactly one.
      w = (cur_weight > WEIGHT_ONE) ? WEIGHT_ONE : cur_weight;
      acc = (64'(ch_smoothed[ch]) * 64'(WEIGHT_ONE - w) + 64'(raw) * 64'(w) + 64'd128) >> 8;
      blend = (acc > 64'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];
      ch_smoothed[ch] = blend;
      diff = (blend >= ch_held[ch]) ? blend - ch_held[ch] : ch_held[ch] - blend;
      if (diff <= cur_max_step) begin
        ch_held[ch] = blend;
        rpt.dist_q8 = blend;
      end else begin
        rpt.dist_q8 = ch_held[ch];
        rpt.rejected = 1'b1;
      end
    end
    return rpt;
  endfunction

  // Waits until every owed report has come back, then lets the pipeline settle.
  task automatic wait_quiet();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one configuration register and mirrors it into the predictor once the
  // transaction is accepted. Callers make sure the block is idle first.
  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (sel)
      REG_DISTANCE_SCALE:    cur_scale = value[SCALE_W-1:0];
      REG_NEW_SAMPLE_WEIGHT: cur_weight = value[WEIGHT_W-1:0];
      REG_MAX_STEP:          cur_max_step = value[DIST_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one echo transaction, possibly after a gap, and holds it until the block
  // takes it. The expected report is queued at the edge that accepts the echo. Valid
  // is left high on return so back-to-back echoes need no extra assignment.
  task automatic send_echo(input logic ch, input logic [CAPTURE_W-1:0] rise,
                           input logic [CAPTURE_W-1:0] fall, input distance_report_t rpt);
    int gap;

    @(negedge clk);
    if (idling && $urandom_range(99) < gap_pct) begin
      echo_valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk);
    end
    echo_valid <= 1'b1;
    channel <= ch;
    rise_time <= rise;
    fall_time <= fall;
    do @(posedge clk); while (echo_stall !== 1'b0);
    pending_reports.push_back(rpt);
  endtask

  // The receiver stalls in random bursts while idling is enabled.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idling) begin
        stall_left = 0;
        result_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Every accepted result transaction is matched against the oldest owed report.
  always @(posedge clk) begin
    distance_report_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        report_error($sformatf("unexpected report ch=%0d dist=%0d rej=%0d",
                               channel_out, distance, spike_rejected));
      end else begin
        want = pending_reports.pop_front();
        if (channel_out !== want.ch)
          report_error($sformatf("channel_out got %0d want %0d", channel_out, want.ch));
        if (distance !== want.dist_q8)
          report_error($sformatf("distance ch=%0d got %0d want %0d",
                                 want.ch, distance, want.dist_q8));
        if (spike_rejected !== want.rejected)
          report_error($sformatf("spike_rejected ch=%0d got %0d want %0d",
                                 want.ch, spike_rejected, want.rejected));
      end
    end
  end

  // Watchdog: counts consecutive cycles in which no transaction of any kind completes.
  initial begin
    @(negedge rst);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((echo_valid && echo_stall === 1'b0) || (result_valid === 1'b1 && !result_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence: reset, directed table, randomized phases, drain and verdict.
  initial begin
    distance_report_t     rpt;
    stim_row_t            row;
    logic [CAPTURE_W-1:0] base_width [2];
    logic [CAPTURE_W-1:0] pulse;
    logic [CAPTURE_W-1:0] rise;
    logic [CAPTURE_W-1:0] fall;
    logic                 ch;
    int                   pick;

    rst = 1'b1;
    echo_valid = 1'b0;
    channel = 1'b0;
    rise_time = '0;
    fall_time = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DISTANCE_SCALE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Register rows wait for the block to go quiet before writing.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        @(negedge clk);
        echo_valid <= 1'b0;
        wait_quiet();
        write_register(row.reg_sel, row.reg_value);
      end else begin
        rpt = filter_echo(row.ch, row.rise, row.fall);
        if (row.typed) begin
          rpt.dist_q8 = row.exp_dist;
          rpt.rejected = row.exp_rej;
        end
        send_echo(row.ch, row.rise, row.fall, rpt);
      end
    end

    // Random part. Each phase picks a fresh register setting, with the extremes
    // weighted in, and its own idling odds; the last phase runs without any idling.
    // Most echoes jitter around a base pulse width per channel so the smoother
    // and the step limiter both see realistic traffic, with jumps, lone spikes and
    // fully random captures mixed in.
    base_width[0] = 16'($urandom_range(500, 25000));
    base_width[1] = 16'($urandom_range(500, 25000));
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      @(negedge clk);
      echo_valid <= 1'b0;
      wait_quiet();
      idling = (phase != RANDOM_PHASES - 1);
      case ($urandom_range(2))
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 40; stall_pct = 40; end
      endcase

      case ($urandom_range(5))
        0: write_register(REG_DISTANCE_SCALE, 19'd0);
        1: write_register(REG_DISTANCE_SCALE, 19'd65535);
        2, 3: write_register(REG_DISTANCE_SCALE, 19'(SCALE_RESET));
        default: write_register(REG_DISTANCE_SCALE, 19'($urandom_range(0, 65535)));
      endcase
      case ($urandom_range(5))
        0: write_register(REG_NEW_SAMPLE_WEIGHT, 19'd0);
        1: write_register(REG_NEW_SAMPLE_WEIGHT, 19'd256);
        2: write_register(REG_NEW_SAMPLE_WEIGHT, 19'($urandom_range(257, 511)));
        3: write_register(REG_NEW_SAMPLE_WEIGHT, 19'(WEIGHT_RESET));
        default: write_register(REG_NEW_SAMPLE_WEIGHT, 19'($urandom_range(0, 256)));
      endcase
      case ($urandom_range(5))
        0: write_register(REG_MAX_STEP, 19'd0);
        1: write_register(REG_MAX_STEP, 19'd524287);
        2, 3: write_register(REG_MAX_STEP, 19'(MAX_STEP_RESET));
        default: write_register(REG_MAX_STEP, 19'($urandom_range(0, 65535)));
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = 1'($urandom_range(1));
        rise = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 65) begin
          pulse = base_width[ch] + 16'($urandom_range(0, 64)) - 16'd32;
        end else if (pick < 80) begin
          base_width[ch] = 16'($urandom_range(0, 65535));
          pulse = base_width[ch];
        end else if (pick < 90) begin
          pulse = 16'($urandom_range(0, 65535));
        end else begin
          pulse = 16'($urandom) - rise;
        end
        fall = rise + pulse;
        rpt = filter_echo(ch, rise, fall);
        send_echo(ch, rise, fall, rpt);
      end
    end

    @(negedge clk);
    echo_valid <= 1'b0;
    wait_quiet();

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/edsf_pkg.sv
rtl/echo_distance_smoothing_filter.sv
tb/sv/tb_echo_distance_smoothing_filter.sv
